### design/sle_pkg.sv
package sle_pkg;

    // list capacity and widths; the index width is derived from the capacity
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int VAL_W = 32;

    // command codes
    localparam logic [3:0] CMD_INS_FRONT = 4'd0;
    localparam logic [3:0] CMD_INS_BACK  = 4'd1;
    localparam logic [3:0] CMD_INS_AT    = 4'd2;
    localparam logic [3:0] CMD_DEL_FRONT = 4'd3;
    localparam logic [3:0] CMD_DEL_BACK  = 4'd4;
    localparam logic [3:0] CMD_DEL_AT    = 4'd5;
    localparam logic [3:0] CMD_FIND      = 4'd6;
    localparam logic [3:0] CMD_SORT      = 4'd7;
    localparam logic [3:0] CMD_DUMP      = 4'd8;
    localparam logic [3:0] CMD_DUMP_REV  = 4'd9;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]              cmd;
        logic signed [VAL_W-1:0] value;
        logic [4:0]              position;
    } sle_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic [CNT_W-1:0]        found_at;
        logic [CNT_W-1:0]        count;
        logic [2:0]              status;
        logic                    last;
    } sle_res_t;

endpackage

### design/sequence_list_engine.sv
// Bounded ordered list of signed 32-bit values with front/back/positional
// insert and delete, find, ascending sort and forward or reverse dump.
// Command channel: cmd_valid/cmd_ready with cmd_data (cmd, value, position).
// Result channel: res_valid/res_ready with res_data; every command gives one
// beat with last set, except a dump of a non-empty list, which gives one
// beat per entry and sets last on the final one. Unused codes give nothing.
// Entries live in a single-port-write, registered-read memory; a sequencer
// walks it one entry per cycle when shifting, searching or sorting, and
// passes each dump entry through a read state and an output state. A sort
// makes passes over n entries, n falling from count, up to count-1 passes.
// cmd_ready is high only while the sequencer is idle;
// a command may be taken while the previous result beat still waits in the
// output register. A stalled receiver holds the result register and the
// sequencer waits before loading the next beat. Reset (rst_n low, async)
// empties the list and drops any pending beat; memory contents are not
// cleared since only entries below the count are ever read.
module sequence_list_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  sle_pkg::sle_cmd_t  cmd_data,
    output logic               res_valid,
    input  logic               res_ready,
    output sle_pkg::sle_res_t  res_data
);
    import sle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOVE,
        S_PUT,
        S_FIND,
        S_SORT,
        S_SORT_END,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } state_t;

    // entry memory
    logic signed [VAL_W-1:0] mem [DEPTH];
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    logic signed [VAL_W-1:0] mem_wd;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [VAL_W-1:0] rd_data_reg;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        src_reg, src_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    pend_v_reg, pend_v_next;
    logic                    pend_cap_reg, pend_cap_next;
    logic [IDX_W-1:0]        pend_a_reg, pend_a_next;
    logic                    first_reg, first_next;
    logic                    ins_reg, ins_next;
    logic                    rev_reg, rev_next;
    logic                    swap_reg, swap_next;
    logic [IDX_W-1:0]        lim_reg, lim_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] item_reg, item_next;
    logic signed [VAL_W-1:0] carry_reg, carry_next;
    logic [CNT_W-1:0]        found_reg, found_next;
    logic [2:0]              status_reg, status_next;
    logic                    out_valid_reg, out_valid_next;
    sle_res_t                out_data_reg, out_data_next;

    logic                    slot_free;
    logic                    load_out;
    sle_res_t                load_data;
    logic [IDX_W-1:0]        pos_idx;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;
    assign slot_free = !out_valid_reg || res_ready;
    assign pos_idx   = IDX_W'(cmd_data.position - 5'd1);

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        src_next      = src_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        pend_v_next   = pend_v_reg;
        pend_cap_next = pend_cap_reg;
        pend_a_next   = pend_a_reg;
        first_next    = first_reg;
        ins_next      = ins_reg;
        rev_next      = rev_reg;
        swap_next     = swap_reg;
        lim_next      = lim_reg;
        val_next      = val_reg;
        item_next     = item_reg;
        carry_next    = carry_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        rd_addr       = src_reg;
        load_out      = 1'b0;
        load_data     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    val_next    = cmd_data.value;
                    item_next   = '0;
                    found_next  = '0;
                    status_next = ST_OK;
                    pend_v_next = 1'b0;
                    unique case (cmd_data.cmd) inside
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_EMIT;
                            end
                            else if (cmd_data.cmd == CMD_INS_AT &&
                                     (cmd_data.position == 5'd0 ||
                                      {1'b0, cmd_data.position} >
                                      ({1'b0, count_reg} + 6'd1)))
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                if (cmd_data.cmd == CMD_INS_FRONT)
                                    idx_next = '0;
                                else if (cmd_data.cmd == CMD_INS_BACK)
                                    idx_next = count_reg[IDX_W-1:0];
                                else
                                    idx_next = pos_idx;
                                ins_next   = 1'b1;
                                first_next = 1'b0;
                                src_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_MOVE;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else if (cmd_data.cmd == CMD_DEL_AT &&
                                     (cmd_data.position == 5'd0 ||
                                      cmd_data.position > count_reg))
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                if (cmd_data.cmd == CMD_DEL_FRONT)
                                    idx_next = '0;
                                else if (cmd_data.cmd == CMD_DEL_BACK)
                                    idx_next = IDX_W'(count_reg - CNT_W'(1));
                                else
                                    idx_next = pos_idx;
                                ins_next   = 1'b0;
                                first_next = 1'b1;
                                state_next = S_MOVE;
                            end
                        end
                        CMD_FIND:
                        begin
                            src_next    = '0;
                            rem_next    = count_reg;
                            status_next = ST_NOTFOUND;
                            state_next  = S_FIND;
                        end
                        CMD_SORT:
                        begin
                            if (count_reg <= CNT_W'(1))
                                state_next = S_EMIT;
                            else
                            begin
                                lim_next   = IDX_W'(count_reg - CNT_W'(1));
                                src_next   = '0;
                                rem_next   = count_reg;
                                swap_next  = 1'b0;
                                state_next = S_SORT;
                            end
                        end
                        CMD_DUMP, CMD_DUMP_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                rev_next   = (cmd_data.cmd == CMD_DUMP_REV);
                                src_next   = (cmd_data.cmd == CMD_DUMP_REV) ?
                                             IDX_W'(count_reg - CNT_W'(1)) : '0;
                                rem_next   = count_reg;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    // insert walks down from the tail, delete walks up from idx
                    if (state_next == S_MOVE)
                    begin
                        if (ins_next)
                            rem_next = count_reg - CNT_W'(idx_next);
                        else
                        begin
                            src_next = idx_next;
                            rem_next = count_reg - CNT_W'(idx_next);
                        end
                    end
                end
            end

            // shift entries one place, one read and one write per cycle
            S_MOVE:
            begin
                if (pend_v_reg)
                begin
                    if (pend_cap_reg)
                        item_next = rd_data_reg;
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = pend_a_reg;
                        mem_wd = rd_data_reg;
                    end
                end
                if (rem_reg != '0)
                begin
                    pend_v_next   = 1'b1;
                    pend_cap_next = first_reg;
                    first_next    = 1'b0;
                    pend_a_next   = ins_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next      = ins_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    rem_next      = rem_reg - 1'b1;
                end
                else
                begin
                    pend_v_next = 1'b0;
                    if (!pend_v_reg)
                    begin
                        if (ins_reg)
                            state_next = S_PUT;
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = S_EMIT;
                        end
                    end
                end
            end

            // drop the new value into the opened slot
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg;
                mem_wd     = val_reg;
                count_next = count_reg + 1'b1;
                state_next = S_EMIT;
            end

            // linear search, first match wins
            S_FIND:
            begin
                if (pend_v_reg && rd_data_reg == val_reg)
                begin
                    found_next  = CNT_W'(pend_a_reg) + CNT_W'(1);
                    status_next = ST_OK;
                    pend_v_next = 1'b0;
                    state_next  = S_EMIT;
                end
                else if (rem_reg != '0)
                begin
                    pend_v_next = 1'b1;
                    pend_a_next = src_reg;
                    src_next    = src_reg + 1'b1;
                    rem_next    = rem_reg - 1'b1;
                end
                else
                begin
                    pend_v_next = 1'b0;
                    if (!pend_v_reg)
                        state_next = S_EMIT;
                end
            end

            // one bubble pass, the larger value rides along in carry
            S_SORT:
            begin
                if (pend_v_reg)
                begin
                    if (pend_a_reg == '0)
                        carry_next = rd_data_reg;
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = pend_a_reg - 1'b1;
                        if (carry_reg > rd_data_reg)
                        begin
                            mem_wd    = rd_data_reg;
                            swap_next = 1'b1;
                        end
                        else
                        begin
                            mem_wd     = carry_reg;
                            carry_next = rd_data_reg;
                        end
                    end
                end
                if (rem_reg != '0)
                begin
                    pend_v_next = 1'b1;
                    pend_a_next = src_reg;
                    src_next    = src_reg + 1'b1;
                    rem_next    = rem_reg - 1'b1;
                end
                else
                begin
                    pend_v_next = 1'b0;
                    if (!pend_v_reg)
                        state_next = S_SORT_END;
                end
            end

            // park the pass maximum, then decide on another pass
            S_SORT_END:
            begin
                mem_we = 1'b1;
                mem_wa = lim_reg;
                mem_wd = carry_reg;
                if (swap_reg && lim_reg > IDX_W'(1))
                begin
                    lim_next   = lim_reg - 1'b1;
                    src_next   = '0;
                    rem_next   = CNT_W'(lim_reg);
                    swap_next  = 1'b0;
                    state_next = S_SORT;
                end
                else
                    state_next = S_EMIT;
            end

            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end

            // one dump beat per entry
            S_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    load_out             = 1'b1;
                    load_data.item_value = rd_data_reg;
                    load_data.found_at   = '0;
                    load_data.count      = count_reg;
                    load_data.status     = ST_OK;
                    load_data.last       = (rem_reg == CNT_W'(1));
                    if (rem_reg == CNT_W'(1))
                        state_next = S_IDLE;
                    else
                    begin
                        src_next   = rev_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                        rem_next   = rem_reg - 1'b1;
                        state_next = S_DUMP_RD;
                    end
                end
            end

            // single result beat
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load_out             = 1'b1;
                    load_data.item_value = item_reg;
                    load_data.found_at   = found_reg;
                    load_data.count      = count_reg;
                    load_data.status     = status_reg;
                    load_data.last       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = load_data;
        end
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    // memory port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        pend_cap_reg <= pend_cap_next;
        pend_a_reg   <= pend_a_next;
        first_reg    <= first_next;
        ins_reg      <= ins_next;
        rev_reg      <= rev_next;
        swap_reg     <= swap_next;
        lim_reg      <= lim_next;
        val_reg      <= val_next;
        item_reg     <= item_next;
        carry_reg    <= carry_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule

### verif/sequence_list_engine_tb.sv
module sequence_list_engine_tb;

    import sle_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 200;
    localparam int PHASE_ITEMS   = 30;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    // codes 10..15 are not decoded by the block
    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;

    localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_M_ONE = -32'sd1;

    typedef enum int {TRAFFIC_FILL, TRAFFIC_MIXED, TRAFFIC_DRAIN} traffic_e;
    typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    sle_cmd_t cmd_data  = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    sle_res_t res_data;

    // list shadow and expected result beats
    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int                      list_len = 0;
    sle_res_t                expected_beats [$];

    // run bookkeeping
    int mismatches   = 0;
    int cmds_taken   = 0;
    int beats_seen   = 0;
    int peak_len     = 0;
    int pauses       = 0;
    int status_hits [8];
    int burst_left   = 0;
    bit sender_steady = 1'b0;

    sequence_list_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // list shadow helpers
    function automatic void list_insert(int idx, logic signed [VAL_W-1:0] v);
        for (int k = list_len; k > idx; k--)
        begin
            list_vals[k] = list_vals[k - 1];
        end
        list_vals[idx] = v;
        list_len++;
        if (list_len > peak_len)
        begin
            peak_len = list_len;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] list_remove(int idx);
        logic signed [VAL_W-1:0] v;
        v = list_vals[idx];
        for (int k = idx; k + 1 < list_len; k++)
        begin
            list_vals[k] = list_vals[k + 1];
        end
        list_len--;
        return v;
    endfunction

    // apply one command to the shadow and queue the beats it must produce
    function automatic void predict_list_cmd(sle_cmd_t c);
        sle_res_t                beat;
        logic signed [VAL_W-1:0] tmp;
        bit                      swapped;
        bit                      single;
        beat   = '0;
        single = 1'b1;
        case (c.cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
            begin
                if (list_len >= DEPTH)
                begin
                    beat.status = ST_FULL;
                end
                else if (c.cmd == CMD_INS_FRONT)
                begin
                    list_insert(0, c.value);
                end
                else if (c.cmd == CMD_INS_BACK)
                begin
                    list_insert(list_len, c.value);
                end
                else if (c.position == 0 || int'(c.position) > list_len + 1)
                begin
                    beat.status = ST_BADPOS;
                end
                else
                begin
                    list_insert(int'(c.position) - 1, c.value);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
            begin
                if (list_len == 0)
                begin
                    beat.status = ST_EMPTY;
                end
                else if (c.cmd == CMD_DEL_FRONT)
                begin
                    beat.item_value = list_remove(0);
                end
                else if (c.cmd == CMD_DEL_BACK)
                begin
                    beat.item_value = list_remove(list_len - 1);
                end
                else if (c.position == 0 || int'(c.position) > list_len)
                begin
                    beat.status = ST_BADPOS;
                end
                else
                begin
                    beat.item_value = list_remove(int'(c.position) - 1);
                end
            end
            CMD_FIND:
            begin
                beat.status = ST_NOTFOUND;
                for (int k = 0; k < list_len; k++)
                begin
                    if (list_vals[k] == c.value)
                    begin
                        beat.found_at = CNT_W'(k + 1);
                        beat.status   = ST_OK;
                        break;
                    end
                end
            end
            CMD_SORT:
            begin
                // bubble passes with early exit, signed ascending
                for (int n = list_len; n > 1; n--)
                begin
                    swapped = 1'b0;
                    for (int k = 0; k + 1 < n; k++)
                    begin
                        if (list_vals[k] > list_vals[k + 1])
                        begin
                            tmp              = list_vals[k];
                            list_vals[k]     = list_vals[k + 1];
                            list_vals[k + 1] = tmp;
                            swapped          = 1'b1;
                        end
                    end
                    if (!swapped)
                    begin
                        break;
                    end
                end
            end
            CMD_DUMP, CMD_DUMP_REV:
            begin
                if (list_len == 0)
                begin
                    beat.status = ST_EMPTY;
                end
                else
                begin
                    // one beat per entry, last flag on the final one
                    single = 1'b0;
                    for (int k = 0; k < list_len; k++)
                    begin
                        beat            = '0;
                        beat.item_value = (c.cmd == CMD_DUMP) ? list_vals[k]
                                                              : list_vals[list_len - 1 - k];
                        beat.count      = CNT_W'(list_len);
                        beat.last       = (k == list_len - 1);
                        expected_beats.push_back(beat);
                    end
                end
            end
            default:
            begin
                // unused code: no beat, no change
                single = 1'b0;
            end
        endcase
        if (single)
        begin
            beat.count = CNT_W'(list_len);
            beat.last  = 1'b1;
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic string beat_text(sle_res_t b);
        return $sformatf("item=%0d found=%0d count=%0d status=%0d last=%0b",
                         b.item_value, b.found_at, b.count, b.status, b.last);
    endfunction

    function automatic void note_mismatch(string detail);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s", $time, detail);
        end
    endfunction

    // send one command beat, then keep the burst/gap rhythm
    task automatic send_cmd(input logic [3:0] op, input logic signed [VAL_W-1:0] v,
                            input logic [4:0] p);
        sle_cmd_t c;
        int       gap;
        c.cmd      = op;
        c.value    = v;
        c.position = p;
        @(negedge clk);
        cmd_data  <= c;
        cmd_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ready);
        predict_list_cmd(c);
        cmds_taken++;
        if (sender_steady || burst_left > 0)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
        end
        else
        begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic idle_sender();
        @(negedge clk);
        cmd_valid <= 1'b0;
    endtask

    // hold off until every expected beat is back, then let the block settle
    task automatic pause_until_drained();
        idle_sender();
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        pauses++;
    endtask

    // every failing command on an empty list, a sort of it, plus an unused code
    task automatic test_empty_list();
        send_cmd(CMD_DEL_FRONT, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_BACK, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd31);
        send_cmd(CMD_FIND, VAL_M_ONE, 5'd0);
        send_cmd(CMD_SORT, 32'sd0, 5'd0);
        send_cmd(CMD_DUMP, 32'sd0, 5'd0);
        send_cmd(CMD_DUMP_REV, 32'sd0, 5'd0);
        send_cmd(CMD_INS_AT, 32'sd7, 5'd0);
        send_cmd(CMD_INS_AT, 32'sd7, 5'd2);
        send_cmd(CMD_FIRST_UNUSED + 4'd5, VAL_M_ONE, 5'd31);
        pause_until_drained();
    endtask

    // value extremes, front/back positions, find, sort, dumps, bad positions
    task automatic test_edge_values();
        send_cmd(CMD_INS_AT, VAL_MIN, 5'd1);
        send_cmd(CMD_INS_BACK, VAL_MAX, 5'd0);
        send_cmd(CMD_INS_FRONT, VAL_M_ONE, 5'd0);
        send_cmd(CMD_INS_AT, 32'sd0, 5'd4);
        send_cmd(CMD_INS_AT, 32'sd1, 5'd3);
        send_cmd(CMD_FIND, VAL_MAX, 5'd0);
        send_cmd(CMD_FIND, 32'sd5, 5'd0);
        send_cmd(CMD_SORT, 32'sd0, 5'd0);
        send_cmd(CMD_DUMP, 32'sd0, 5'd0);
        send_cmd(CMD_DUMP_REV, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd6);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd5);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd1);
        send_cmd(CMD_DEL_FRONT, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_BACK, 32'sd0, 5'd0);
        pause_until_drained();
    endtask

    function automatic logic [3:0] pick_op(traffic_e kind);
        int r;
        int ins_w;
        int del_w;
        r = $urandom_range(0, 99);
        case (kind)
            TRAFFIC_FILL:
            begin
                ins_w = 75;
                del_w = 8;
            end
            TRAFFIC_DRAIN:
            begin
                ins_w = 12;
                del_w = 60;
            end
            default:
            begin
                ins_w = 40;
                del_w = 30;
            end
        endcase
        if (r < ins_w)
        begin
            case (r % 3)
                0: return CMD_INS_FRONT;
                1: return CMD_INS_BACK;
                default: return CMD_INS_AT;
            endcase
        end
        if (r < ins_w + del_w)
        begin
            case (r % 3)
                0: return CMD_DEL_FRONT;
                1: return CMD_DEL_BACK;
                default: return CMD_DEL_AT;
            endcase
        end
        r = $urandom_range(0, 19);
        if (r < 8)
        begin
            return CMD_FIND;
        end
        if (r < 11)
        begin
            return CMD_SORT;
        end
        if (r < 15)
        begin
            return CMD_DUMP;
        end
        if (r < 18)
        begin
            return CMD_DUMP_REV;
        end
        return CMD_FIRST_UNUSED + 4'($urandom_range(0, 5));
    endfunction

    // phases that fill, mix and drain the list, with random contents
    task automatic test_random_traffic();
        int                      done_items;
        int                      phase;
        traffic_e                kind;
        logic [3:0]              op;
        logic signed [VAL_W-1:0] v;
        logic [4:0]              p;
        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            kind          = traffic_e'(phase % 3);
            sender_steady = (phase % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS && done_items < RANDOM_ITEMS; i++)
            begin
                op = pick_op(kind);
                v  = $urandom;
                p  = 5'($urandom_range(0, 31));
                // small values give duplicates and sign mixes for find and sort
                if (op == CMD_INS_FRONT || op == CMD_INS_BACK || op == CMD_INS_AT)
                begin
                    case ($urandom_range(0, 9))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2, 3, 4: v = $signed($urandom_range(0, 6)) - 32'sd3;
                        default: ;
                    endcase
                end
                if (op == CMD_FIND && list_len > 0 && $urandom_range(0, 9) < 6)
                begin
                    v = list_vals[$urandom_range(0, list_len - 1)];
                end
                if (op == CMD_INS_AT && $urandom_range(0, 4) != 0)
                begin
                    p = 5'($urandom_range(1, list_len + 1));
                end
                if (op == CMD_DEL_AT && list_len > 0 && $urandom_range(0, 4) != 0)
                begin
                    p = 5'($urandom_range(1, list_len));
                end
                send_cmd(op, v, p);
                if (op < CMD_FIRST_UNUSED)
                begin
                    done_items++;
                end
            end
            if (phase % 2 == 1)
            begin
                pause_until_drained();
            end
            phase++;
        end
        sender_steady = 1'b0;
    endtask

    // receiver back-pressure, mode and mask redrawn when the rx_left countdown runs out
    rx_mode_e   rx_mode  = RX_STEADY;
    int         rx_left  = 0;
    logic [7:0] rx_mask  = 8'hff;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_mask = 8'($urandom);
            rx_left = $urandom_range(20, 80);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            RX_STEADY:  res_ready <= 1'b1;
            RX_LIGHT:   res_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:   res_ready <= ($urandom_range(0, 3) == 0);
            default:    res_ready <= rx_mask[rx_left % 8];
        endcase
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        sle_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            beats_seen++;
            status_hits[res_data.status]++;
            if (expected_beats.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat %s", beat_text(res_data)));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (res_data.item_value !== want.item_value ||
                    res_data.found_at !== want.found_at ||
                    res_data.count !== want.count ||
                    res_data.status !== want.status ||
                    res_data.last !== want.last)
                begin
                    note_mismatch($sformatf("beat %0d want %s got %s", beats_seen,
                                            beat_text(want), beat_text(res_data)));
                end
            end
        end
    end

    // end the run if no beat moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("no handshake for %0d cycles, %0d beats outstanding",
                 STALL_LIMIT, expected_beats.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        test_random_traffic();

        // wait out outstanding beats, then watch for strays
        idle_sender();
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            mismatches += expected_beats.size();
            $display("%0d expected beats never arrived", expected_beats.size());
        end

        $display("covered %0d commands, %0d result beats, peak length %0d, %0d drain pauses",
                 cmds_taken, beats_seen, peak_len, pauses);
        $display("status seen: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_BADPOS], status_hits[ST_NOTFOUND]);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sequence_list_engine.f
design/sle_pkg.sv
design/sequence_list_engine.sv
verif/sequence_list_engine_tb.sv
